// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication check failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");

`endif

// ----- src/fmvs_pkg.sv -----
// ----------------------------------------------------------------------------
// fmvs_pkg
// Types, constants and lookup tables of the four-voice one-bit sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package fmvs_pkg;

    localparam int SCORE_DEPTH   = 16384;
    localparam int INDEX_DEPTH   = 512;
    localparam int SAMPLE_DEPTH  = 128;
    localparam int MAX_LOOP_NEST = 5;
    localparam int VOICES        = 4;
    localparam int PULSE_VOICES  = 3;

    localparam int PTR_W     = 14;
    localparam int SCORE_AW  = $clog2(SCORE_DEPTH);
    localparam int INDEX_AW  = $clog2(INDEX_DEPTH);
    localparam int SAMPLE_AW = $clog2(SAMPLE_DEPTH);
    localparam int LOOP_AW   = (MAX_LOOP_NEST > 1) ? $clog2(MAX_LOOP_NEST) : 1;
    localparam int LD_W      = $clog2(MAX_LOOP_NEST + 1);
    localparam int VOICE_W   = 2;

    // Operations
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_SCORE   = 3'd1;
    localparam logic [2:0] OP_INDEX   = 3'd2;
    localparam logic [2:0] OP_SAMPLE  = 3'd3;
    localparam logic [2:0] OP_RESTART = 3'd4;

    // Score byte high nibble classes
    localparam logic [3:0] HI_REST = 4'd0;
    localparam logic [3:0] HI_LAST_NOTE = 4'd12;
    localparam logic [3:0] HI_STEP = 4'd13;
    localparam logic [3:0] HI_DUTY = 4'd14;
    localparam logic [3:0] HI_CMD  = 4'd15;
    localparam logic [3:0] HI_LAST_SAMPLE = 4'd5;

    // Command codes (low nibble when high nibble is HI_CMD)
    localparam logic [3:0] CMD_LOOP     = 4'd0;
    localparam logic [3:0] CMD_LOOP_END = 4'd1;
    localparam logic [3:0] CMD_CALL     = 4'd2;
    localparam logic [3:0] CMD_TEMPO    = 4'd3;
    localparam logic [3:0] CMD_RETURN   = 4'd15;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SAMPLE,
        ST_POST,
        ST_VSEL,
        ST_FETCH,
        ST_DECODE,
        ST_ARG,
        ST_IDX
    } fmvs_state_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [13:0] address;
        logic [15:0] value;
    } fmvs_item_t;

    typedef struct packed {
        logic       post;
        logic [3:0] bits;
    } fmvs_res_t;

    // Oscillator period per note; entry zero is the rest default
    function automatic logic [10:0] pitch_of(input logic [3:0] hi);
        logic [10:0] p;
        case (hi)
            4'd1:    p = 11'd1024;
            4'd2:    p = 11'd967;
            4'd3:    p = 11'd912;
            4'd4:    p = 11'd861;
            4'd5:    p = 11'd813;
            4'd6:    p = 11'd767;
            4'd7:    p = 11'd724;
            4'd8:    p = 11'd683;
            4'd9:    p = 11'd645;
            4'd10:   p = 11'd609;
            4'd11:   p = 11'd575;
            4'd12:   p = 11'd542;
            default: p = 11'd255;
        endcase
        return p;
    endfunction

    // Sample boundaries within the sample memory
    function automatic logic [7:0] sample_start(input logic [3:0] i);
        logic [7:0] s;
        case (i)
            4'd1:    s = 8'd19;
            4'd2:    s = 8'd34;
            4'd3:    s = 8'd74;
            4'd4:    s = 8'd118;
            4'd5:    s = 8'd126;
            default: s = 8'd0;
        endcase
        return s;
    endfunction

    // Note length in tempo steps
    function automatic logic [6:0] note_len(input logic [3:0] lo);
        logic [6:0] n;
        if (lo[3]) begin
            n = 7'd95 >> lo[2:0];
        end else begin
            n = 7'd127 >> lo[2:0];
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- src/fmvs_ram.sv -----
// ----------------------------------------------------------------------------
// fmvs_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fmvs_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- src/fmvs_engine.sv -----
// ----------------------------------------------------------------------------
// fmvs_engine
// Voice state, memories and the sequencer that runs one transaction.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fmvs_engine (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire fmvs_pkg::fmvs_item_t item,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [13:0]        cfg_data,
    input  wire logic               res_room,
    output logic                    idle,
    output fmvs_pkg::fmvs_res_t     res
);
    import fmvs_pkg::*;

    fmvs_state_t state_reg, state_next;

    logic [PTR_W-1:0]   sp_reg     [VOICES];
    logic [PTR_W-1:0]   sp_next    [VOICES];
    logic [PTR_W-1:0]   rp_reg     [VOICES];
    logic [PTR_W-1:0]   rp_next    [VOICES];
    logic [PTR_W-1:0]   ret_reg    [VOICES];
    logic [PTR_W-1:0]   ret_next   [VOICES];
    logic [LD_W-1:0]    ld_reg     [VOICES];
    logic [LD_W-1:0]    ld_next    [VOICES];
    logic [7:0]         lrep_reg   [VOICES][MAX_LOOP_NEST];
    logic [7:0]         lrep_next  [VOICES][MAX_LOOP_NEST];
    logic [PTR_W-1:0]   lst_reg    [VOICES][MAX_LOOP_NEST];
    logic [PTR_W-1:0]   lst_next   [VOICES][MAX_LOOP_NEST];
    logic [4:0]         step_reg   [VOICES];
    logic [4:0]         step_next  [VOICES];
    logic [3:0]         dsh_reg    [VOICES];
    logic [3:0]         dsh_next   [VOICES];
    logic [6:0]         nt_reg     [VOICES];
    logic [6:0]         nt_next    [VOICES];
    logic [15:0]        phase_reg  [PULSE_VOICES];
    logic [15:0]        phase_next [PULSE_VOICES];
    logic [10:0]        period_reg [PULSE_VOICES];
    logic [10:0]        period_next[PULSE_VOICES];
    logic [10:0]        duty_reg   [PULSE_VOICES];
    logic [10:0]        duty_next  [PULSE_VOICES];

    logic [3:0]  level_reg, level_next;
    logic [15:0] tcnt_reg, tcnt_next;
    logic [11:0] trel_reg, trel_next;
    logic [2:0]  sdiv_reg, sdiv_next;
    logic [7:0]  sbyte_reg, sbyte_next;
    logic [3:0]  sbit_reg, sbit_next;
    logic [7:0]  send_reg, send_next;
    logic [VOICE_W-1:0] vidx_reg, vidx_next;
    logic [7:0]  guard_reg, guard_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic        idx_oob_reg, idx_oob_next;
    logic        score_oob_reg;
    logic        sample_oob_reg;
    fmvs_res_t   res_next;

    // Memory ports
    logic                 score_we, index_we, sample_we;
    logic [31:0]          score_wa32, score_ra32, sample_ra32;
    logic [SCORE_AW-1:0]  score_raddr;
    logic [INDEX_AW-1:0]  index_raddr;
    logic [SAMPLE_AW-1:0] sample_raddr;
    logic [7:0]           score_rdata, sample_rdata;
    logic [15:0]          index_rdata;
    logic [7:0]           score_q;
    logic [PTR_W-1:0]     score_rptr;
    logic [10:0]          idx_full;

    // Decode of the current voice step
    logic [3:0] hi, lo, cmd_lo;
    logic       need_idx, step_cont, note_done, last_voice, guard_last;
    logic [PTR_W-1:0] cur_rp;

    assign cur_rp      = rp_reg[vidx_reg];
    assign score_q     = score_oob_reg ? 8'd0 : score_rdata;
    assign hi          = score_q[7:4];
    assign lo          = score_q[3:0];
    assign cmd_lo      = cmd_reg[3:0];
    assign last_voice  = (vidx_reg == VOICE_W'(VOICES - 1));
    assign guard_last  = (guard_reg == 8'hFF);
    assign need_idx    = (state_reg == ST_ARG) &&
                         ((cmd_lo == CMD_CALL) ||
                          ((cmd_lo == CMD_RETURN) && (ret_reg[vidx_reg] == '0)));
    assign step_cont   = ((state_reg == ST_DECODE) && ((hi == HI_STEP) || (hi == HI_DUTY))) ||
                         ((state_reg == ST_ARG) && !need_idx) ||
                         (state_reg == ST_IDX);
    assign note_done   = (state_reg == ST_DECODE) && (hi <= HI_LAST_NOTE);
    assign idle        = (state_reg == ST_IDLE);

    // Memory addressing; score read is pointer, or pointer+1 for the argument
    assign score_rptr  = (state_reg == ST_DECODE) ? PTR_W'(cur_rp + 1'b1) : cur_rp;
    assign score_ra32  = 32'(score_rptr);
    assign score_raddr = score_ra32[SCORE_AW-1:0];
    assign score_wa32  = 32'(item.address);
    assign score_we    = start && (item.operation == OP_SCORE) &&
                         (score_wa32 < 32'(SCORE_DEPTH));
    assign index_we    = start && (item.operation == OP_INDEX) &&
                         (score_wa32 < 32'(INDEX_DEPTH));
    assign sample_we   = start && (item.operation == OP_SAMPLE) &&
                         (score_wa32 < 32'(SAMPLE_DEPTH));
    assign idx_full    = (cmd_lo == CMD_CALL) ? (11'(score_q) + 11'(VOICES)) : 11'(vidx_reg);
    assign index_raddr = idx_full[INDEX_AW-1:0];
    assign sample_ra32 = 32'(sbyte_reg);
    assign sample_raddr = sample_ra32[SAMPLE_AW-1:0];

    fmvs_ram #(.DEPTH(SCORE_DEPTH), .WIDTH(8)) u_score (
        .clk   (clk),
        .we    (score_we),
        .waddr (score_wa32[SCORE_AW-1:0]),
        .wdata (item.value[7:0]),
        .raddr (score_raddr),
        .rdata (score_rdata)
    );

    fmvs_ram #(.DEPTH(INDEX_DEPTH), .WIDTH(16)) u_index (
        .clk   (clk),
        .we    (index_we),
        .waddr (score_wa32[INDEX_AW-1:0]),
        .wdata (item.value),
        .raddr (index_raddr),
        .rdata (index_rdata)
    );

    fmvs_ram #(.DEPTH(SAMPLE_DEPTH), .WIDTH(8)) u_sample (
        .clk   (clk),
        .we    (sample_we),
        .waddr (score_wa32[SAMPLE_AW-1:0]),
        .wdata (item.value[7:0]),
        .raddr (sample_raddr),
        .rdata (sample_rdata)
    );

    // Out-of-range flags travel with the read data
    always_ff @(posedge clk)
    begin
        score_oob_reg  <= (score_ra32 >= 32'(SCORE_DEPTH));
        sample_oob_reg <= (sample_ra32 >= 32'(SAMPLE_DEPTH));
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && (item.operation == OP_TICK))
                begin
                    state_next = ST_SAMPLE;
                end
            end
            ST_SAMPLE: state_next = ST_POST;
            ST_POST:
            begin
                if (res_room)
                begin
                    state_next = (tcnt_reg == '0) ? ST_VSEL : ST_IDLE;
                end
            end
            ST_VSEL:
            begin
                if (nt_reg[vidx_reg] == '0)
                begin
                    state_next = ST_FETCH;
                end
                else
                begin
                    state_next = last_voice ? ST_IDLE : ST_VSEL;
                end
            end
            ST_FETCH: state_next = ST_DECODE;
            default:
            begin
                if ((state_reg == ST_DECODE) && (hi == HI_CMD))
                begin
                    state_next = ST_ARG;
                end
                else if (need_idx)
                begin
                    state_next = ST_IDX;
                end
                else if ((step_cont && guard_last) || note_done)
                begin
                    state_next = last_voice ? ST_IDLE : ST_VSEL;
                end
                else if (step_cont)
                begin
                    state_next = ST_FETCH;
                end
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        logic [15:0] ph;
        logic [3:0]  pulses;
        logic        bit3;
        logic [3:0]  sbit_n;
        logic [7:0]  smp;
        logic [LD_W-1:0] d;
        logic [LOOP_AW-1:0] dtop;
        logic [10:0] pitch;

        sp_next = sp_reg;  rp_next = rp_reg;  ret_next = ret_reg;  ld_next = ld_reg;
        lrep_next = lrep_reg;  lst_next = lst_reg;  step_next = step_reg;
        dsh_next = dsh_reg;  nt_next = nt_reg;  phase_next = phase_reg;
        period_next = period_reg;  duty_next = duty_reg;
        level_next = level_reg;  tcnt_next = tcnt_reg;  trel_next = trel_reg;
        sdiv_next = sdiv_reg;  sbyte_next = sbyte_reg;  sbit_next = sbit_reg;
        send_next = send_reg;  vidx_next = vidx_reg;  guard_next = guard_reg;
        cmd_next = cmd_reg;  idx_oob_next = idx_oob_reg;
        res_next = '{post: 1'b0, bits: res.bits};
        ph = '0;  pulses = '0;  bit3 = 1'b0;  sbit_n = '0;  smp = '0;
        d = ld_reg[vidx_reg];
        dtop = LOOP_AW'(d - 1'b1);
        pitch = pitch_of(hi);

        // Configuration and restart
        if (cfg_we)
        begin
            sp_next[cfg_index] = cfg_data;
        end
        if (start && (item.operation == OP_RESTART))
        begin
            rp_next = sp_reg;
        end

        case (state_reg)
            ST_POST:
            begin
                if (res_room)
                begin
                    // Sampler step
                    bit3 = level_reg[3];
                    sbit_n = sbit_reg;
                    if (sdiv_reg == '0)
                    begin
                        if ((9'(sbyte_reg) + 9'd1) < 9'(send_reg))
                        begin
                            smp = sample_oob_reg ? 8'd0 : sample_rdata;
                            bit3 = smp[sbit_reg[2:0]];
                            sbit_n = sbit_reg + 4'd1;
                        end
                        else
                        begin
                            bit3 = 1'b0;
                        end
                        if (sbit_n > 4'd7)
                        begin
                            sbyte_next = sbyte_reg + 8'd1;
                            sbit_n = '0;
                        end
                        sbit_next = sbit_n;
                        sdiv_next = 3'd5;
                    end
                    else
                    begin
                        sdiv_next = sdiv_reg - 3'd1;
                    end
                    res_next = '{post: 1'b1, bits: {bit3, level_reg[2:0]}};

                    // Pulse oscillators
                    for (int i = 0; i < PULSE_VOICES; i++)
                    begin
                        ph = phase_reg[i] + 16'(step_reg[i]);
                        if (ph >= 16'(period_reg[i]))
                        begin
                            ph = ph - 16'(period_reg[i]);
                        end
                        phase_next[i] = ph;
                        pulses[i] = (ph < 16'(duty_reg[i]));
                    end
                    level_next = {bit3, pulses[2:0]};

                    // Tempo
                    vidx_next = '0;
                    if (tcnt_reg == '0)
                    begin
                        tcnt_next = 16'(trel_reg);
                    end
                    else
                    begin
                        tcnt_next = tcnt_reg - 16'd1;
                    end
                end
            end
            ST_VSEL:
            begin
                guard_next = '0;
                if (nt_reg[vidx_reg] != '0)
                begin
                    nt_next[vidx_reg] = nt_reg[vidx_reg] - 7'd1;
                    vidx_next = vidx_reg + 1'b1;
                end
            end
            ST_DECODE:
            begin
                cmd_next = score_q;
                if (hi == HI_STEP)
                begin
                    step_next[vidx_reg] = 5'(lo) + 5'd1;
                    rp_next[vidx_reg] = cur_rp + 1'b1;
                end
                else if (hi == HI_DUTY)
                begin
                    dsh_next[vidx_reg] = lo;
                    rp_next[vidx_reg] = cur_rp + 1'b1;
                end
                else if (hi != HI_CMD)
                begin
                    // Note or rest
                    if (vidx_reg != VOICE_W'(VOICES - 1))
                    begin
                        if (hi != HI_REST)
                        begin
                            period_next[vidx_reg] = pitch;
                            duty_next[vidx_reg] = pitch >> dsh_reg[vidx_reg];
                        end
                        else
                        begin
                            duty_next[vidx_reg] = '0;
                        end
                    end
                    else if (hi != HI_REST)
                    begin
                        sbit_next = '0;
                        if (hi <= HI_LAST_SAMPLE)
                        begin
                            sbyte_next = sample_start(hi - 4'd1);
                            send_next = sample_start(hi);
                        end
                        else
                        begin
                            sbyte_next = '0;
                            send_next = '0;
                        end
                    end
                    nt_next[vidx_reg] = note_len(lo);
                    rp_next[vidx_reg] = cur_rp + 1'b1;
                    vidx_next = vidx_reg + 1'b1;
                end
            end
            ST_ARG:
            begin
                idx_oob_next = (32'(idx_full) >= 32'(INDEX_DEPTH));
                case (cmd_lo)
                    CMD_LOOP:
                    begin
                        if (32'(d) < 32'(MAX_LOOP_NEST))
                        begin
                            lst_next[vidx_reg][LOOP_AW'(d)] = cur_rp + PTR_W'(3);
                            lrep_next[vidx_reg][LOOP_AW'(d)] = score_q;
                            ld_next[vidx_reg] = d + 1'b1;
                        end
                        rp_next[vidx_reg] = cur_rp + PTR_W'(2);
                    end
                    CMD_LOOP_END:
                    begin
                        if ((d == '0) || (32'(d) > 32'(MAX_LOOP_NEST)))
                        begin
                            rp_next[vidx_reg] = cur_rp + 1'b1;
                        end
                        else if (lrep_reg[vidx_reg][dtop] != '0)
                        begin
                            rp_next[vidx_reg] = lst_reg[vidx_reg][dtop];
                            lrep_next[vidx_reg][dtop] = lrep_reg[vidx_reg][dtop] - 8'd1;
                        end
                        else
                        begin
                            ld_next[vidx_reg] = d - 1'b1;
                            rp_next[vidx_reg] = cur_rp + 1'b1;
                        end
                    end
                    CMD_CALL:
                    begin
                        ret_next[vidx_reg] = cur_rp + PTR_W'(2);
                    end
                    CMD_TEMPO:
                    begin
                        trel_next = {score_q, 4'h0};
                        rp_next[vidx_reg] = cur_rp + PTR_W'(2);
                    end
                    CMD_RETURN:
                    begin
                        if (ret_reg[vidx_reg] != '0)
                        begin
                            rp_next[vidx_reg] = ret_reg[vidx_reg];
                            ret_next[vidx_reg] = '0;
                        end
                    end
                    default:
                    begin
                        rp_next[vidx_reg] = cur_rp + 1'b1;
                    end
                endcase
            end
            ST_IDX:
            begin
                rp_next[vidx_reg] = idx_oob_reg ? '0 : index_rdata[PTR_W-1:0];
            end
            default:
            begin
            end
        endcase

        // Bookkeeping after a command byte
        if (step_cont)
        begin
            guard_next = guard_reg + 8'd1;
            if (guard_last)
            begin
                vidx_next = vidx_reg + 1'b1;
            end
        end
    end

    // Registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            for (int v = 0; v < VOICES; v++)
            begin
                sp_reg[v]   <= '0;
                rp_reg[v]   <= '0;
                ret_reg[v]  <= '0;
                ld_reg[v]   <= '0;
                step_reg[v] <= 5'd3;
                dsh_reg[v]  <= 4'd1;
                nt_reg[v]   <= '0;
                for (int k = 0; k < MAX_LOOP_NEST; k++)
                begin
                    lrep_reg[v][k] <= '0;
                    lst_reg[v][k]  <= '0;
                end
            end
            for (int i = 0; i < PULSE_VOICES; i++)
            begin
                phase_reg[i]  <= '0;
                period_reg[i] <= 11'd255;
                duty_reg[i]   <= '0;
            end
            level_reg   <= '0;
            tcnt_reg    <= '0;
            trel_reg    <= '0;
            sdiv_reg    <= '0;
            sbyte_reg   <= '0;
            sbit_reg    <= '0;
            send_reg    <= '0;
            vidx_reg    <= '0;
            guard_reg   <= '0;
            cmd_reg     <= '0;
            idx_oob_reg <= 1'b0;
            res         <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            sp_reg      <= sp_next;
            rp_reg      <= rp_next;
            ret_reg     <= ret_next;
            ld_reg      <= ld_next;
            lrep_reg    <= lrep_next;
            lst_reg     <= lst_next;
            step_reg    <= step_next;
            dsh_reg     <= dsh_next;
            nt_reg      <= nt_next;
            phase_reg   <= phase_next;
            period_reg  <= period_next;
            duty_reg    <= duty_next;
            level_reg   <= level_next;
            tcnt_reg    <= tcnt_next;
            trel_reg    <= trel_next;
            sdiv_reg    <= sdiv_next;
            sbyte_reg   <= sbyte_next;
            sbit_reg    <= sbit_next;
            send_reg    <= send_next;
            vidx_reg    <= vidx_next;
            guard_reg   <= guard_next;
            cmd_reg     <= cmd_next;
            idx_oob_reg <= idx_oob_next;
            res         <= res_next;
        end
    end

    // Checks
    `ASSERT_IMPLIES(a_start_idle, clk, rst_n, start, state_reg == ST_IDLE)
    `ASSERT_NEXT(a_tick_runs, clk, rst_n, start && (item.operation == OP_TICK), state_reg == ST_SAMPLE)
    `ASSERT_NEXT(a_post_room, clk, rst_n, (state_reg == ST_POST) && res_room, res.post)
    `ASSERT_IMPLIES(a_loop_depth, clk, rst_n, 1'b1, 32'(ld_reg[0]) <= 32'(MAX_LOOP_NEST))

endmodule

`default_nettype wire

// ----- src/four_voice_one_bit_music_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// four_voice_one_bit_music_sequencer_top
// One-bit four-voice music sequencer with score, index and sample memories.
// ----------------------------------------------------------------------------
// A write or restart transaction is done when it is accepted. A tick steps
// through accept, sample memory read, then sampler, oscillators and result
// (the last waits for room at the output) when the tempo counter is running;
// when it expires, add a select step per voice, plus for each score byte a
// voice interprets a score memory read and a decode, an argument step for
// a command with an argument byte and an index memory read for a call or
// return that needs it. Up to 256 bytes per voice per tempo step. The result
// sits in an output register; the next transaction is taken while it waits.
`default_nettype none

module four_voice_one_bit_music_sequencer_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  operation,
    input  wire logic [13:0] address,
    input  wire logic [15:0] value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [3:0]       channel_bits,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [13:0] cfg_data
);
    import fmvs_pkg::*;

    logic       eng_idle;
    logic       res_room;
    fmvs_res_t  res;
    fmvs_item_t item;
    logic       out_valid_reg, out_valid_next;
    logic [3:0] bits_reg, bits_next;

    assign item      = '{operation: operation, address: address, value: value};
    assign in_ready  = eng_idle;
    assign res_room  = !out_valid_reg || out_ready;

    fmvs_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_valid && in_ready),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_room  (res_room),
        .idle      (eng_idle),
        .res       (res)
    );

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        bits_next      = bits_reg;
        if (res.post)
        begin
            out_valid_next = 1'b1;
            bits_next      = res.bits;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
    end

    assign out_valid    = out_valid_reg;
    assign channel_bits = bits_reg;

endmodule

`default_nettype wire
